[sv/sd_wide_bus_data_crc_macros.svh]
// Assertion shorthands for the checker file.
`ifndef SD_WIDE_BUS_DATA_CRC_MACROS_SVH
`define SD_WIDE_BUS_DATA_CRC_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define SDWB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define SDWB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sdwb_pkg.sv]
`default_nettype none

package sdwb_pkg;

    localparam int unsigned LINES       = 4;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned TRL_BYTES   = 8;
    localparam int unsigned TRL_W       = TRL_BYTES * 8;
    localparam int unsigned TRL_CNT_W   = 4;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef logic [CRC_W-1:0]            crc_t;
    typedef logic [LINES-1:0][CRC_W-1:0] crc_bank_t;
    typedef logic [TRL_W-1:0]            trl_img_t;
    typedef logic [TRL_CNT_W-1:0]        trl_cnt_t;

    // top -> trailer unit
    typedef struct packed {
        logic load;
        logic advance;
    } trl_ctrl_t;

    // trailer unit -> top
    typedef struct packed {
        logic busy;
        logic last;
    } trl_stat_t;

    // one bit into a CRC16, MSB first
    function automatic crc_t crc_push(input crc_t crc, input logic din);
        logic fb;
        crc_t c;
        fb = crc[CRC_W-1] ^ din;
        c  = {crc[CRC_W-2:0], 1'b0};
        if (fb) begin
            c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Trailer image: byte t at [63-8t -: 8]; bit 4+k = line k bit 15-2t,
    // bit k = line k bit 14-2t.
    function automatic trl_img_t trl_pack(input crc_bank_t bank);
        trl_img_t img;
        img = '0;
        for (int t = 0; t < TRL_BYTES; t++) begin
            for (int k = 0; k < LINES; k++) begin
                img[TRL_W - 8 - 8*t + 4 + k] = bank[k][CRC_W - 1 - 2*t];
                img[TRL_W - 8 - 8*t + k]     = bank[k][CRC_W - 2 - 2*t];
            end
        end
        return img;
    endfunction

endpackage

`default_nettype wire

[sv/sdwb_crc_lane.sv]
`default_nettype none

// CRC16 for one data line: two bits per byte, high nibble bit first.
module sdwb_crc_lane
    import sdwb_pkg::*;
(
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  en,
    input  wire  clr,
    input  wire  bit_hi,
    input  wire  bit_lo,
    output crc_t crc_next
);

    crc_t crc_reg;

    assign crc_next = crc_push(crc_push(crc_reg, bit_hi), bit_lo);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= '0;
        end else if (en) begin
            crc_reg <= clr ? '0 : crc_next;
        end
    end

endmodule

`default_nettype wire

[sv/sdwb_trailer.sv]
`default_nettype none

// Holds the packed CRC trailer and shifts it out a byte at a time.
module sdwb_trailer
    import sdwb_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  trl_ctrl_t  ctrl,
    input  crc_bank_t  bank,
    output logic [7:0] trl_byte,
    output trl_stat_t  stat
);

    trl_img_t shift_reg;
    trl_cnt_t cnt_reg;

    assign trl_byte  = shift_reg[TRL_W-1 -: 8];
    assign stat.busy = (cnt_reg != '0);
    assign stat.last = (cnt_reg == trl_cnt_t'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctrl.load) begin
            cnt_reg <= trl_cnt_t'(TRL_BYTES);
        end else if (ctrl.advance) begin
            cnt_reg <= cnt_reg - trl_cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            shift_reg <= trl_pack(bank);
        end else if (ctrl.advance) begin
            shift_reg <= {shift_reg[TRL_W-9:0], 8'h00};
        end
    end

endmodule

`default_nettype wire

[sv/sd_wide_bus_data_crc.sv]
// Data CRC generator for a 4-bit card bus. Each accepted word on the s_
// channel is one data byte; it comes out unchanged on the m_ channel with
// m_is_crc low, while four CRC16 registers (x^16+x^12+x^5+1, seed 0, MSB
// first), one per data line, take two bits of it: line k gets bit 4+k, then
// bit k. The byte flagged by s_end_of_block is followed by eight trailer
// words (m_is_crc high, m_last high on the eighth); trailer word t carries
// CRC bits 15-2t of lines 3..0 in its high nibble and bits 14-2t in its low
// nibble. The CRCs restart from zero right after that byte. Rate: one word
// per cycle in both directions while m_ready is high, except that s_ready
// stays low while the trailer shift register drains. Words pass through one
// output register. Block length is not checked.
`default_nettype none

module sd_wide_bus_data_crc
    import sdwb_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    // byte stream in
    input  wire        s_valid,
    output logic       s_ready,
    input  wire  [7:0] s_data_byte,
    input  wire        s_end_of_block,
    // byte stream out
    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_is_crc,
    output logic       m_last
);

    logic       out_free;
    logic       s_accept;
    logic       eob_accept;
    crc_bank_t  crc_next;
    trl_ctrl_t  trl_ctrl;
    trl_stat_t  trl_stat;
    logic [7:0] trl_byte;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_out_byte_reg;
    logic       m_is_crc_reg;
    logic       m_last_reg;

    // output register is free when empty or being drained this cycle
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = out_free && !trl_stat.busy;
    assign s_accept   = s_valid && s_ready;
    assign eob_accept = s_accept && s_end_of_block;

    assign trl_ctrl.load    = eob_accept;
    assign trl_ctrl.advance = out_free && trl_stat.busy;

    // one CRC per data line
    for (genvar k = 0; k < LINES; k++) begin : g_lane
        sdwb_crc_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (s_accept),
            .clr      (s_end_of_block),
            .bit_hi   (s_data_byte[4+k]),
            .bit_lo   (s_data_byte[k]),
            .crc_next (crc_next[k])
        );
    end

    // trailer snapshot takes the CRCs including the final byte
    sdwb_trailer u_trl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (trl_ctrl),
        .bank     (crc_next),
        .trl_byte (trl_byte),
        .stat     (trl_stat)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept || trl_ctrl.advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload: data byte on accept, trailer byte on advance (never both)
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_out_byte_reg <= s_data_byte;
            m_is_crc_reg   <= 1'b0;
            m_last_reg     <= 1'b0;
        end else if (trl_ctrl.advance) begin
            m_out_byte_reg <= trl_byte;
            m_is_crc_reg   <= 1'b1;
            m_last_reg     <= trl_stat.last;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_is_crc   = m_is_crc_reg;
    assign m_last     = m_last_reg;

endmodule

`default_nettype wire

[sv/sdwb_checker.sv]
`default_nettype none

`include "sd_wide_bus_data_crc_macros.svh"

module sdwb_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire [7:0] s_data_byte,
    input wire       s_end_of_block,
    input wire       m_valid,
    input wire       m_ready,
    input wire [7:0] m_out_byte,
    input wire       m_is_crc,
    input wire       m_last
);

    // stalled output word holds
    `SDWB_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_is_crc) && $stable(m_last), "output word changed while stalled")

    // last only marks a trailer word
    `SDWB_ASSERT_IMP(a_last_is_crc, m_valid && m_last, m_is_crc, "last set on a data word")

    // input closes once a block end is taken
    `SDWB_ASSERT_NXT(a_eob_stall, s_valid && s_ready && s_end_of_block, !s_ready, "input open right after block end")

    // trailer words follow each other without a gap
    `SDWB_ASSERT_NXT(a_trl_run, m_valid && m_ready && m_is_crc && !m_last, m_valid && m_is_crc, "gap inside the trailer")

endmodule

bind sd_wide_bus_data_crc sdwb_checker u_sdwb_checker (.*);

`default_nettype wire

[tb/sd_wide_bus_data_crc_tb.sv]
module sd_wide_bus_data_crc_tb;
    import sdwb_pkg::*;

    // Cycles with no word moving on either side before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Length of the forced receiver hold-off that backs the block up.
    localparam int LONG_HOLD      = 80;
    // Random words per idle phase; the directed block comes on top of phase 0.
    localparam int PHASE_WORDS    = 40;

    typedef struct {
        logic [7:0] value;
        logic       eob;
    } data_item_t;

    typedef struct {
        logic [7:0] value;
        logic       is_crc;
        logic       last;
    } bus_word_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte    = 8'h00;
    logic       s_end_of_block = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_is_crc;
    logic       m_last;

    // Bytes waiting for the driver, and words the block still owes us.
    data_item_t pending_bytes[$];
    bus_word_t  expected_words[$];

    // Per-line CRC shadow, one register per data line.
    crc_t crc_lines [LINES];

    // Idle mix, set by the sequencer; percent out of a hundred.
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    logic        hold_req      = 1'b0;

    int bytes_sent     = 0;
    int words_checked  = 0;
    int blocks_closed  = 0;
    int mismatch_count = 0;
    int stall_count    = 0;

    sd_wide_bus_data_crc dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_block (s_end_of_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_is_crc       (m_is_crc),
        .m_last         (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // One bit into a line CRC, MSB first: feedback is the outgoing MSB xor the data bit.
    function automatic crc_t crc_shift(input crc_t c, input logic b);
        logic fb;
        fb = c[CRC_W-1] ^ b;
        c  = c << 1;
        if (fb) begin
            c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // Advance the line CRCs by one accepted byte and queue the words it should produce.
    function automatic void track_byte(input logic [7:0] d, input logic eob);
        bus_word_t  w;
        logic [7:0] tb;
        // line k carries bit 4+k first, then bit k
        for (int k = 0; k < LINES; k++) begin
            crc_lines[k] = crc_shift(crc_shift(crc_lines[k], d[4+k]), d[k]);
        end
        w = '{value: d, is_crc: 1'b0, last: 1'b0};
        expected_words.push_back(w);
        if (eob) begin
            // trailer word t: high nibble = bit 15-2t of lines 3..0, low nibble = bit 14-2t
            for (int t = 0; t < TRL_BYTES; t++) begin
                for (int k = 0; k < LINES; k++) begin
                    tb[4+k] = crc_lines[k][CRC_W-1-2*t];
                    tb[k]   = crc_lines[k][CRC_W-2-2*t];
                end
                w = '{value: tb, is_crc: 1'b1, last: (t == TRL_BYTES - 1)};
                expected_words.push_back(w);
            end
            for (int k = 0; k < LINES; k++) begin
                crc_lines[k] = '0;
            end
            blocks_closed++;
        end
    endfunction

    function automatic void note_mismatch(input string what, input bus_word_t exp_w);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("word %0d: %s exp byte=%02h crc=%0b last=%0b got byte=%02h crc=%0b last=%0b",
                     words_checked, what, exp_w.value, exp_w.is_crc, exp_w.last,
                     m_out_byte, m_is_crc, m_last);
        end
    endfunction

    // Driver: counts accepted bytes into the shadow, then offers the next one or idles.
    always @(posedge aclk) begin
        data_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_byte(s_data_byte, s_end_of_block);
                bytes_sent++;
            end
            // only move on once the current word is gone; valid never drops on its own
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    item = pending_bytes.pop_front();
                    s_valid        <= 1'b1;
                    s_data_byte    <= item.value;
                    s_end_of_block <= item.eob;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output word against the oldest expectation, owns m_ready.
    int   hold_left  = 0;
    logic hold_taken = 1'b0;

    always @(posedge aclk) begin
        bus_word_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    exp_w = '{value: 8'h00, is_crc: 1'b0, last: 1'b0};
                    note_mismatch("unexpected word", exp_w);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (m_out_byte !== exp_w.value) note_mismatch("out_byte", exp_w);
                    if (m_is_crc !== exp_w.is_crc)  note_mismatch("is_crc", exp_w);
                    if (m_last !== exp_w.last)      note_mismatch("last", exp_w);
                end
                words_checked++;
            end
            // one long hold-off on request; the sender keeps pushing meanwhile
            if (hold_req && !hold_taken) begin
                hold_left  = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Watchdog: a run of cycles with nothing accepted on either side means a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_count <= 0;
            end else begin
                stall_count <= stall_count + 1;
            end
            if (stall_count >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d idle cycles, %0d words still owed",
                         stall_count, expected_words.size());
                $display("sd_wide_bus_data_crc: mismatch");
                $finish;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] v, input logic eob);
        data_item_t item;
        item = '{value: v, eob: eob};
        pending_bytes.push_back(item);
    endtask

    // Random block; mostly short, now and then a longer one.
    task automatic queue_random_block(output int len);
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
            queue_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    task automatic drain_sender;
        while (pending_bytes.size() != 0 || s_valid) @(negedge aclk);
    endtask

    // Sequencer: works on the falling edge so it never races the clocked processes.
    initial begin
        int unsigned src_mix [4];
        int unsigned snk_mix [4];
        int          phase_words;
        int          len;

        src_mix = '{0, 56, 0, 28};
        snk_mix = '{0, 0, 56, 28};
        for (int k = 0; k < LINES; k++) begin
            crc_lines[k] = '0;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: one-byte blocks with all-zero, all-one and single-bit data,
        // mixed patterns, and a block that runs on for a while before closing.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'h01, 1'b1);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h0F, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b1);
        for (int i = 0; i < 4; i++) queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'h81, 1'b1);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct  = src_mix[p];
            snk_stall_pct = snk_mix[p];
            // back-pressure test rides on the no-idle phase so the sender keeps offering
            if (p == 0) hold_req = 1'b1;
            phase_words = 0;
            while (phase_words < PHASE_WORDS) begin
                queue_random_block(len);
                phase_words += len;
            end
            drain_sender();
        end

        while (expected_words.size() != 0) @(negedge aclk);
        // output register latency plus margin, watching for stray words
        repeat (8) @(negedge aclk);

        $display("run covered %0d data bytes in %0d closed blocks, %0d output words checked,",
                 bytes_sent, blocks_closed, words_checked);
        $display("under four sender/receiver idle mixes and one long receiver hold-off");
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("sd_wide_bus_data_crc: match");
        end else begin
            $display("%0d field mismatches, %0d words never arrived",
                     mismatch_count, expected_words.size());
            $display("sd_wide_bus_data_crc: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/sdwb_pkg.sv
sv/sdwb_crc_lane.sv
sv/sdwb_trailer.sv
sv/sd_wide_bus_data_crc.sv
sv/sdwb_checker.sv
tb/sd_wide_bus_data_crc_tb.sv
